>>> hdl/fatcw_pkg.sv
// shared types and constants for the fat cluster chain walker
package fatcw_pkg;

    localparam int unsigned FAT_BYTES_DEF = 65536;
    localparam int unsigned MAX_RUN_DEF   = 64;

    localparam logic [2:0] REG_BPS   = 3'd0;
    localparam logic [2:0] REG_SPC   = 3'd1;
    localparam logic [2:0] REG_RSV   = 3'd2;
    localparam logic [2:0] REG_NFAT  = 3'd3;
    localparam logic [2:0] REG_ROOT  = 3'd4;
    localparam logic [2:0] REG_TOTAL = 3'd5;
    localparam logic [2:0] REG_FATSZ = 3'd6;

    typedef enum logic [1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_LOW   = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam logic [27:0] EOF12 = 28'h0000FFF;
    localparam logic [27:0] EOF16 = 28'h000FFFF;
    localparam logic [27:0] EOF32 = 28'hFFFFFFF;
    localparam logic [63:0] LIM16 = 64'd4085;
    localparam logic [63:0] LIM32 = 64'd65525;

    typedef enum logic [4:0] {
        S_IDLE,
        S_G_ROOT,
        S_G_DIV,
        S_G_MUL,
        S_G_OVH,
        S_G_SUB,
        S_G_KIND,
        S_CHECK,
        S_MUL,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_RD4,
        S_NEXT,
        S_OUT
    } t_state;

    // geometry registers as seen by the walker
    typedef struct packed {
        logic [12:0] bps;
        logic [7:0]  spc;
        logic [15:0] rsv;
        logic [7:0]  nfat;
        logic [15:0] root;
        logic [31:0] total;
        logic [31:0] fatsz;
    } t_geom;

endpackage

>>> hdl/fatcw_regs.sv
// configuration register file; flags each accepted write so the geometry can be marked stale
module fatcw_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output fatcw_pkg::t_geom     o_geom,
    output logic                 o_cfg_write
);
    import fatcw_pkg::*;

    t_geom r_geom;

    assign o_geom      = r_geom;
    assign o_cfg_write = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.bps   <= 13'd512;
            r_geom.spc   <= 8'd1;
            r_geom.rsv   <= 16'd1;
            r_geom.nfat  <= 8'd2;
            r_geom.root  <= 16'd224;
            r_geom.total <= 32'd2880;
            r_geom.fatsz <= 32'd9;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BPS:   r_geom.bps   <= i_cfg_data[12:0];
                REG_SPC:   r_geom.spc   <= i_cfg_data[7:0];
                REG_RSV:   r_geom.rsv   <= i_cfg_data[15:0];
                REG_NFAT:  r_geom.nfat  <= i_cfg_data[7:0];
                REG_ROOT:  r_geom.root  <= i_cfg_data[15:0];
                REG_TOTAL: r_geom.total <= i_cfg_data;
                REG_FATSZ: r_geom.fatsz <= i_cfg_data;
                default: ;
            endcase
        end
    end
endmodule

>>> hdl/fatcw_store.sv
// fat byte store, one write or one read per cycle, registered read
module fatcw_store #(
    parameter int unsigned FAT_BYTES = fatcw_pkg::FAT_BYTES_DEF,
    localparam int unsigned AW = $clog2(FAT_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [FAT_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> hdl/fat_cluster_chain_walker.sv
// top level of the fat cluster chain walker
// Usage: geometry registers are written through the cfg channel (index 0..6,
// other indexes are taken and ignored) while the block is idle. Each input
// transfer is either a load (func 0), which writes one byte of the FAT store
// in the cycle it is taken if the address lies in the store, so loads can
// follow back to back, or a walk (func 1). A walk emits one result transfer
// per cluster of the chain, up to MAX_RUN, the last one with o_last_of_run
// set. After any register write the first walk recomputes the geometry: a
// bit-serial divide for the root directory sectors, one 32x8 multiply, an
// add of the overhead sectors, a subtract and a compare of the data sectors
// against the type limits scaled by the cluster size. Each chain link passes
// a check of the cluster against two, the sector multiply with the store
// bounds check, FAT reads of two bytes (four for FAT32) on the single store
// read port, the next-cluster decode and the output register. A cluster below
// two ends the walk with ST_LOW, an entry outside the store with ST_RANGE.
// The block holds its input ready low for the whole walk; when the receiver
// stalls the result stays in the output register and the walk waits. Reset
// restores the register defaults and sets FAT12 with the geometry marked
// stale; the FAT store is not cleared and must be loaded before it is walked.
module fat_cluster_chain_walker #(
    parameter int unsigned FAT_BYTES = fatcw_pkg::FAT_BYTES_DEF,
    parameter int unsigned MAX_RUN   = fatcw_pkg::MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [15:0] i_fat_byte_addr,
    input  logic [7:0]  i_fat_byte_data,
    input  logic [27:0] i_start_cluster,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [27:0] o_cluster_num,
    output logic [31:0] o_first_sector,
    output logic [1:0]  o_walk_status,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fatcw_pkg::*;

    localparam int unsigned AW = $clog2(FAT_BYTES);
    localparam int unsigned RW = $clog2(MAX_RUN + 1);
    localparam logic [RW-1:0] RUN_LAST = RW'(MAX_RUN - 1);

    t_geom      w_geom;
    logic       w_cfg_write;
    t_state     r_state, n_state;
    logic       r_gvalid;
    t_kind      r_kind;
    logic [31:0] r_dstart;
    logic [27:0] r_cur;
    logic [RW-1:0] r_n;
    logic [63:0] r_acc, r_tmp;   // shared wide working registers
    logic [5:0]  r_cnt;
    logic [31:0] r_next;
    logic [AW-1:0] r_raddr;
    logic [31:0] r_sec;
    logic [7:0]  w_rdata;
    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [30:0] w_off;
    logic [30:0] w_end;
    logic [27:0] w_eof;
    logic [27:0] w_nval;
    logic [31:0] w_sec;
    logic [7:0]  w_spc1;
    logic [23:0] w_lim16, w_lim32;

    assign o_cfg_ready = (r_state == S_IDLE);

    fatcw_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_geom     (w_geom),
        .o_cfg_write(w_cfg_write)
    );

    assign o_ready = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_we    = i_valid && o_ready && !i_func
                     && ({16'd0, i_fat_byte_addr} < 32'(FAT_BYTES));
    assign w_addr  = w_we ? AW'(i_fat_byte_addr) : r_raddr;

    fatcw_store #(.FAT_BYTES(FAT_BYTES)) u_store (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .i_we   (w_we),
        .i_wdata(i_fat_byte_data),
        .o_rdata(w_rdata)
    );

    // first sector of the current cluster, wraps at 32 bits
    assign w_sec = r_dstart + ({4'd0, r_cur} - 32'd2) * {24'd0, w_geom.spc};

    // cluster count below a limit means data sectors below limit times cluster size
    assign w_spc1  = (w_geom.spc == 8'd0) ? 8'd1 : w_geom.spc;
    assign w_lim16 = {8'd0, LIM16[15:0]} * {16'd0, w_spc1};
    assign w_lim32 = {8'd0, LIM32[15:0]} * {16'd0, w_spc1};

    // byte offset and end of the current entry
    always_comb begin
        unique case (r_kind)
            KIND_FAT12: begin
                w_off = 31'(({3'd0, r_cur} + {2'd0, r_cur, 1'b0}) >> 1);
                w_end = w_off + 31'd2;
                w_eof = EOF12;
            end
            KIND_FAT16: begin
                w_off = {2'd0, r_cur, 1'b0};
                w_end = w_off + 31'd2;
                w_eof = EOF16;
            end
            default: begin
                w_off = {1'b0, r_cur, 2'b0};
                w_end = w_off + 31'd4;
                w_eof = EOF32;
            end
        endcase
    end

    always_comb begin
        unique case (r_kind)
            KIND_FAT12: w_nval = r_cur[0] ? {16'd0, r_next[15:4]} : {16'd0, r_next[11:0]};
            KIND_FAT16: w_nval = {12'd0, r_next[15:0]};
            default:    w_nval = r_next[27:0];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready && i_func)
                n_state = r_gvalid ? S_CHECK : S_G_ROOT;
            S_G_ROOT: n_state = S_G_DIV;
            S_G_DIV:  if (r_cnt == 6'd0) n_state = S_G_MUL;
            S_G_MUL:  n_state = S_G_OVH;
            S_G_OVH:  n_state = S_G_SUB;
            S_G_SUB:  n_state = S_G_KIND;
            S_G_KIND: n_state = S_CHECK;
            S_CHECK: begin
                if (r_cur < 28'd2) n_state = S_OUT;
                else n_state = S_MUL;
            end
            S_MUL: n_state = (w_end > 31'(FAT_BYTES)) ? S_OUT : S_RD0;
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = (r_kind == KIND_FAT32) ? S_RD3 : S_NEXT;
            S_RD3: n_state = S_RD4;
            S_RD4: n_state = S_NEXT;
            S_NEXT: n_state = S_OUT;
            S_OUT: if (!o_valid) n_state = S_OUT;
                   else if (i_ready) n_state = o_last_of_run ? S_IDLE : S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gvalid <= 1'b0;
            r_kind   <= KIND_FAT12;
            r_dstart <= 32'd0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_write) r_gvalid <= 1'b0;
            if (r_state == S_G_KIND) begin
                r_gvalid <= 1'b1;
                r_dstart <= r_tmp[31:0];
                if (r_acc < {40'd0, w_lim16})      r_kind <= KIND_FAT12;
                else if (r_acc < {40'd0, w_lim32}) r_kind <= KIND_FAT16;
                else                               r_kind <= KIND_FAT32;
            end
            if (o_valid && i_ready) o_valid <= 1'b0;
            else if (r_state == S_OUT && !o_valid && n_state == S_OUT) o_valid <= 1'b0;
            if ((r_state == S_CHECK && r_cur < 28'd2)
                || (r_state == S_MUL && w_end > 31'(FAT_BYTES))
                || r_state == S_NEXT)
                o_valid <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cur <= i_start_cluster;
                r_n   <= '0;
            end
            S_G_ROOT: begin
                // root bytes rounded up, divided bit-serially below
                r_acc <= {43'd0, w_geom.root, 5'd0} + {51'd0, w_geom.bps} - 64'd1;
                r_tmp <= 64'd0;
                r_cnt <= 6'd21;
            end
            S_G_DIV: begin
                // restoring divide of r_acc[21:0] by bps, quotient in r_tmp
                r_cnt <= r_cnt - 6'd1;
                if (w_geom.bps == 13'd0) begin
                    r_tmp <= 64'd0;
                end else if ({r_tmp[63:22], r_acc[21]} >= {29'd0, w_geom.bps}) begin
                    r_tmp <= {r_tmp[62:22], r_acc[21], 22'd0}
                             - {29'd0, w_geom.bps, 22'd0} | {42'd0, r_tmp[20:0], 1'b1};
                end else begin
                    r_tmp <= {r_tmp[62:22], r_acc[21], r_tmp[20:0], 1'b0};
                end
                r_acc <= {r_acc[62:0], 1'b0};
            end
            S_G_MUL: begin
                r_acc <= {32'd0, w_geom.fatsz} * {56'd0, w_geom.nfat};
                r_tmp <= {42'd0, r_tmp[21:0]};
            end
            S_G_OVH: r_tmp <= r_acc + r_tmp + {48'd0, w_geom.rsv};
            S_G_SUB: r_acc <= ({32'd0, w_geom.total} > r_tmp)
                              ? {32'd0, w_geom.total} - r_tmp : 64'd0;
            S_CHECK: begin
                r_raddr <= AW'(w_off);
                r_next  <= 32'd0;
            end
            S_MUL: r_sec <= w_sec;
            S_RD0: r_raddr <= r_raddr + AW'(1);
            S_RD1: begin
                r_next[7:0] <= w_rdata;
                r_raddr     <= r_raddr + AW'(1);
            end
            S_RD2: begin
                r_next[15:8] <= w_rdata;
                r_raddr      <= r_raddr + AW'(1);
            end
            S_RD3: r_next[23:16] <= w_rdata;
            S_RD4: r_next[31:24] <= w_rdata;
            S_OUT: if (o_valid && i_ready) begin
                r_cur <= w_nval;
                r_n   <= r_n + RW'(1);
            end
            default: ;
        endcase
        // result register
        if (r_state == S_CHECK && r_cur < 28'd2) begin
            o_cluster_num  <= r_cur;
            o_first_sector <= 32'd0;
            o_walk_status  <= ST_LOW;
            o_last_of_run  <= 1'b1;
        end else if (r_state == S_MUL && w_end > 31'(FAT_BYTES)) begin
            o_cluster_num  <= r_cur;
            o_first_sector <= w_sec;
            o_walk_status  <= ST_RANGE;
            o_last_of_run  <= 1'b1;
        end else if (r_state == S_NEXT) begin
            o_cluster_num  <= r_cur;
            o_first_sector <= r_sec;
            if (w_nval == w_eof) begin
                o_walk_status <= ST_OK;
                o_last_of_run <= 1'b1;
            end else if (r_n >= RUN_LAST) begin
                o_walk_status <= ST_TRUNC;
                o_last_of_run <= 1'b1;
            end else begin
                o_walk_status <= ST_OK;
                o_last_of_run <= 1'b0;
            end
        end
    end
endmodule
